>>> src/wcv_pkg.sv
// shared types and constants for the weighted window class vote core
// no dependencies; used by the core and the testbench
package wcv_pkg;

  localparam int ANGLE_W  = 13;
  localparam int PIXELS_W = 20;
  localparam int WEIGHT_W = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 20;

  localparam int WINDOW_DEF = 16;

  localparam logic [ANGLE_W-1:0]  ANGLE_MIN_RST = 13'd0;
  localparam logic [ANGLE_W-1:0]  ANGLE_MAX_RST = 13'd5760;
  localparam logic [PIXELS_W-1:0] THRESH_RST    = 20'd0;
  localparam logic [WEIGHT_W-1:0] UP_WEIGHT_RST = 4'd3;

  typedef enum logic [1:0] {
    CLS_UP      = 2'd0,
    CLS_OTHER   = 2'd1,
    CLS_CHANGED = 2'd2,
    CLS_IDLE    = 2'd3
  } cls_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ANGLE_MIN   = 3'd0,
    CFG_ANGLE_MAX   = 3'd1,
    CFG_THRESHOLD   = 3'd2,
    CFG_UP_WEIGHT   = 3'd3
  } cfg_idx_t;

endpackage

>>> src/weighted_window_class_vote_core.sv
// throughput 1 item per cycle while the result output is not stalled
// classification and window count update happen as the item is accepted,
// the weighted tally compare then runs on the stage 1 item into the result register
// the window is a shift line of WINDOW entries, so the entry leaving is always the last tap
// reset (rst_n low, synchronous) empties the window, clears counts and restores
// register defaults; cfg_ready is always high
module weighted_window_class_vote_core #(
  parameter int WINDOW = wcv_pkg::WINDOW_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [wcv_pkg::ANGLE_W-1:0]    in_motion_angle,
  input  logic                           in_angle_valid,
  input  logic [wcv_pkg::PIXELS_W-1:0]   in_changed_pixels,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_frame_class,
  output logic [1:0]                     out_window_winner,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [wcv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wcv_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CNT_W   = $clog2(WINDOW + 1);
  localparam int SCORE_W = CNT_W + wcv_pkg::WEIGHT_W;
  localparam int LAST    = WINDOW - 1;

  logic [wcv_pkg::ANGLE_W-1:0]  angle_min_r;
  logic [wcv_pkg::ANGLE_W-1:0]  angle_max_r;
  logic [wcv_pkg::PIXELS_W-1:0] thresh_r;
  logic [wcv_pkg::WEIGHT_W-1:0] up_weight_r;

  logic          ring_vld_r [WINDOW];
  wcv_pkg::cls_t ring_cls_r [WINDOW];
  logic [CNT_W-1:0] cnt_r   [4];
  logic [CNT_W-1:0] cnt_nxt [4];

  logic          s1_vld_r;
  wcv_pkg::cls_t s1_cls_r;
  logic          out_vld_r;
  logic [1:0]    out_cls_r;
  logic [1:0]    out_win_r;

  logic          out_free;
  logic          in_fire;
  wcv_pkg::cls_t cls;
  logic [1:0]    winner;
  logic [SCORE_W-1:0] score [4];

  assign cfg_ready = 1'b1;
  assign out_free  = !out_vld_r || out_ready;
  assign in_ready  = !s1_vld_r || out_free;
  assign in_fire   = in_valid && in_ready;

  assign out_valid         = out_vld_r;
  assign out_frame_class   = out_cls_r;
  assign out_window_winner = out_win_r;

  // frame classification
  always_comb begin
    if (in_angle_valid) begin
      if (in_motion_angle >= angle_min_r && in_motion_angle <= angle_max_r) begin
        cls = wcv_pkg::CLS_UP;
      end else begin
        cls = wcv_pkg::CLS_OTHER;
      end
    end else if (in_changed_pixels > thresh_r) begin
      cls = wcv_pkg::CLS_CHANGED;
    end else begin
      cls = wcv_pkg::CLS_IDLE;
    end
  end

  // counts: add the new class, drop the entry leaving the window
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      cnt_nxt[c] = cnt_r[c]
                 + CNT_W'(cls == wcv_pkg::cls_t'(c))
                 - CNT_W'(ring_vld_r[LAST] && ring_cls_r[LAST] == wcv_pkg::cls_t'(c));
    end
  end

  // weighted tally, up weighted, ties to lowest index
  always_comb begin
    score[0] = SCORE_W'(cnt_r[0]) * SCORE_W'(up_weight_r);
    for (int c = 1; c < 4; c++) begin
      score[c] = SCORE_W'(cnt_r[c]);
    end
  end

  always_comb begin
    logic [SCORE_W-1:0] best;
    best   = score[0];
    winner = wcv_pkg::CLS_UP;
    for (int c = 1; c < 4; c++) begin
      if (score[c] > best) begin
        best   = score[c];
        winner = 2'(c);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_min_r <= wcv_pkg::ANGLE_MIN_RST;
      angle_max_r <= wcv_pkg::ANGLE_MAX_RST;
      thresh_r    <= wcv_pkg::THRESH_RST;
      up_weight_r <= wcv_pkg::UP_WEIGHT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        wcv_pkg::CFG_ANGLE_MIN: angle_min_r <= cfg_wdata[wcv_pkg::ANGLE_W-1:0];
        wcv_pkg::CFG_ANGLE_MAX: angle_max_r <= cfg_wdata[wcv_pkg::ANGLE_W-1:0];
        wcv_pkg::CFG_THRESHOLD: thresh_r    <= cfg_wdata[wcv_pkg::PIXELS_W-1:0];
        wcv_pkg::CFG_UP_WEIGHT: up_weight_r <= cfg_wdata[wcv_pkg::WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // window shift line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) begin
        ring_vld_r[i] <= 1'b0;
      end
      for (int c = 0; c < 4; c++) begin
        cnt_r[c] <= '0;
      end
    end else if (in_fire) begin
      ring_vld_r[0] <= 1'b1;
      for (int i = 1; i < WINDOW; i++) begin
        ring_vld_r[i] <= ring_vld_r[i-1];
      end
      for (int c = 0; c < 4; c++) begin
        cnt_r[c] <= cnt_nxt[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ring_cls_r[0] <= cls;
      for (int i = 1; i < WINDOW; i++) begin
        ring_cls_r[i] <= ring_cls_r[i-1];
      end
    end
  end

  // stage 1 holds the class, counts already match it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_vld_r <= in_valid;
      end
      if (out_free) begin
        out_vld_r <= s1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cls_r <= cls;
    end
    if (out_free && s1_vld_r) begin
      out_cls_r <= s1_cls_r;
      out_win_r <= winner;
    end
  end

endmodule

>>> src/wcv_checker.sv
// port-level checker for weighted_window_class_vote_core
// watches handshake and result ports only; bound to the core below
module wcv_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_frame_class,
  input logic [1:0] out_window_winner,
  input logic       cfg_valid,
  input logic       cfg_ready
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_class)
                                && $stable(out_window_winner))
    else $error("result changed while stalled");

  // a fresh result comes from an item the input took, passed through stage 1 and the result register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without matching item");

  // input only backs up when the output is stalled
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with free output");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // register writes are never refused
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("config write refused");

endmodule

bind weighted_window_class_vote_core wcv_checker u_wcv_checker (.*);

>>> sim/tb_weighted_window_class_vote_core.sv
`timescale 1ns / 1ps
// testbench for weighted_window_class_vote_core: drives frames and register writes,
// predicts each frame class and window winner, and checks every result item in order
// depends on wcv_pkg and the core in src
module tb_weighted_window_class_vote_core;

  localparam logic [wcv_pkg::CFG_IDX_W-1:0] CFG_FIRST_UNUSED = 3'd4;
  localparam int HOLD_CYCLES = 150;
  localparam int QUIET_LIMIT = 1000;
  localparam int REPORT_CAP = 100;
  localparam int SETTLE_CYCLES = 4;

  class window_vote_tally;
    logic [wcv_pkg::ANGLE_W-1:0]  lo_angle;
    logic [wcv_pkg::ANGLE_W-1:0]  hi_angle;
    logic [wcv_pkg::PIXELS_W-1:0] threshold;
    logic [wcv_pkg::WEIGHT_W-1:0] up_wt;
    bit                           slot_used [wcv_pkg::WINDOW_DEF];
    wcv_pkg::cls_t                slot_class [wcv_pkg::WINDOW_DEF];
    int unsigned                  next_slot;
    int unsigned                  class_count [4];
    wcv_pkg::cls_t                due_class [$];
    wcv_pkg::cls_t                due_winner [$];
    int unsigned                  mismatches;

    function new();
      lo_angle = wcv_pkg::ANGLE_MIN_RST;
      hi_angle = wcv_pkg::ANGLE_MAX_RST;
      threshold = wcv_pkg::THRESH_RST;
      up_wt = wcv_pkg::UP_WEIGHT_RST;
      foreach (slot_used[i]) begin
        slot_used[i] = 1'b0;
        slot_class[i] = wcv_pkg::CLS_UP;
      end
      foreach (class_count[i]) class_count[i] = 0;
      next_slot = 0;
      mismatches = 0;
    endfunction

    function void set_register(logic [wcv_pkg::CFG_IDX_W-1:0] idx,
                               logic [wcv_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        wcv_pkg::CFG_ANGLE_MIN: lo_angle = data[wcv_pkg::ANGLE_W-1:0];
        wcv_pkg::CFG_ANGLE_MAX: hi_angle = data[wcv_pkg::ANGLE_W-1:0];
        wcv_pkg::CFG_THRESHOLD: threshold = data[wcv_pkg::PIXELS_W-1:0];
        wcv_pkg::CFG_UP_WEIGHT: up_wt = data[wcv_pkg::WEIGHT_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_frame(logic [wcv_pkg::ANGLE_W-1:0] ang, logic av,
                             logic [wcv_pkg::PIXELS_W-1:0] pix);
      wcv_pkg::cls_t cls;
      wcv_pkg::cls_t win;
      int unsigned   best_score;
      int            k;
      if (av) begin
        cls = (ang >= lo_angle && ang <= hi_angle) ? wcv_pkg::CLS_UP : wcv_pkg::CLS_OTHER;
      end else begin
        cls = (pix > threshold) ? wcv_pkg::CLS_CHANGED : wcv_pkg::CLS_IDLE;
      end
      if (slot_used[next_slot] && class_count[slot_class[next_slot]] > 0)
        class_count[slot_class[next_slot]]--;
      slot_class[next_slot] = cls;
      slot_used[next_slot] = 1'b1;
      class_count[cls]++;
      next_slot = (next_slot + 1) % wcv_pkg::WINDOW_DEF;
      // up votes carry the weight, the rest count once; ties keep the lower class
      best_score = class_count[wcv_pkg::CLS_UP] * up_wt;
      win = wcv_pkg::CLS_UP;
      for (k = 1; k < 4; k++) begin
        if (class_count[k] > best_score) begin
          best_score = class_count[k];
          win = wcv_pkg::cls_t'(k);
        end
      end
      due_class.push_back(cls);
      due_winner.push_back(win);
    endfunction

    function void note_mismatch(string what, int want, int got);
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endfunction

    function void check_result(logic [1:0] got_class, logic [1:0] got_winner);
      wcv_pkg::cls_t want_class;
      wcv_pkg::cls_t want_winner;
      if (due_class.size() == 0) begin
        note_mismatch("unexpected item frame_class", -1, got_class);
        return;
      end
      want_class = due_class.pop_front();
      want_winner = due_winner.pop_front();
      if (got_class !== want_class) note_mismatch("frame_class", want_class, got_class);
      if (got_winner !== want_winner) note_mismatch("window_winner", want_winner, got_winner);
    endfunction

    function int pending();
      return due_class.size();
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [wcv_pkg::ANGLE_W-1:0]    in_motion_angle = '0;
  logic                           in_angle_valid = 1'b0;
  logic [wcv_pkg::PIXELS_W-1:0]   in_changed_pixels = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [1:0]                     out_frame_class;
  logic [1:0]                     out_window_winner;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [wcv_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [wcv_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  bit src_gaps = 1'b1;
  bit sink_stalls = 1'b1;
  bit long_hold_req = 1'b0;
  bit hold_off_busy = 1'b0;

  window_vote_tally frames = new();

  weighted_window_class_vote_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_motion_angle  (in_motion_angle),
    .in_angle_valid   (in_angle_valid),
    .in_changed_pixels(in_changed_pixels),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_class  (out_frame_class),
    .out_window_winner(out_window_winner),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #5 clk = ~clk;

  task automatic offer_frame(logic [wcv_pkg::ANGLE_W-1:0] ang, logic av,
                             logic [wcv_pkg::PIXELS_W-1:0] pix);
    logic took;
    if (src_gaps && !long_hold_req && !hold_off_busy && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_motion_angle <= ang;
    in_angle_valid <= av;
    in_changed_pixels <= pix;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = (in_ready === 1'b1);
      if (took) frames.note_frame(ang, av, pix);
      @(posedge clk);
    end
  endtask

  task automatic write_register(logic [wcv_pkg::CFG_IDX_W-1:0] idx,
                                logic [wcv_pkg::CFG_DATA_W-1:0] data);
    logic took;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = (cfg_ready === 1'b1);
      if (took) frames.set_register(idx, data);
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (frames.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_ready <= 1'b0;
        hold_off_busy = 1'b1;
        long_hold_req = 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_busy = 1'b0;
        out_ready <= 1'b1;
      end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [1:0] cls_seen;
    logic [1:0] win_seen;
    forever begin
      @(negedge clk);
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        cls_seen = out_frame_class;
        win_seen = out_window_winner;
        @(posedge clk);
        frames.check_result(cls_seen, win_seen);
      end
    end
  end

  initial begin
    int  quiet;
    bit  moved;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(negedge clk);
      moved = (in_valid === 1'b1 && in_ready === 1'b1) ||
              (out_valid === 1'b1 && out_ready === 1'b1) ||
              (cfg_valid === 1'b1 && cfg_ready === 1'b1);
      @(posedge clk);
      quiet = moved ? 0 : quiet + 1;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int                           phase;
    int                           n;
    logic [wcv_pkg::ANGLE_W-1:0]  ang;
    logic [wcv_pkg::ANGLE_W-1:0]  lo;
    logic [wcv_pkg::ANGLE_W-1:0]  hi;
    logic                         av;
    logic [wcv_pkg::PIXELS_W-1:0] pix;
    logic [wcv_pkg::PIXELS_W-1:0] thr;
    logic [wcv_pkg::PIXELS_W-1:0] hi_data;
    logic [wcv_pkg::WEIGHT_W-1:0] wt;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // register defaults, window starts empty
    offer_frame(13'd0, 1'b1, 20'd0);
    offer_frame(13'd5760, 1'b1, 20'hFFFFF);
    offer_frame(13'd5761, 1'b1, 20'd0);
    offer_frame(13'h1FFF, 1'b1, 20'd0);
    offer_frame(13'd0, 1'b0, 20'd0);
    offer_frame(13'h1FFF, 1'b0, 20'd1);
    offer_frame(13'd5759, 1'b0, 20'hFFFFF);
    offer_frame(13'd2880, 1'b1, 20'h55555);
    wait_idle();

    // inverted range, heaviest up weight, unused index
    write_register(wcv_pkg::CFG_ANGLE_MIN, 20'd3000);
    write_register(wcv_pkg::CFG_ANGLE_MAX, 20'd2000);
    write_register(wcv_pkg::CFG_THRESHOLD, 20'd1000);
    write_register(wcv_pkg::CFG_UP_WEIGHT, 20'd15);
    write_register(CFG_FIRST_UNUSED, 20'hFFFFF);
    offer_frame(13'd2500, 1'b1, 20'd0);
    offer_frame(13'd3000, 1'b1, 20'd0);
    offer_frame(13'd0, 1'b1, 20'd0);
    offer_frame(13'd4000, 1'b0, 20'd1000);
    offer_frame(13'd4000, 1'b0, 20'd1001);
    wait_idle();

    // zero up weight, every angle up: window fills with up votes worth nothing
    write_register(wcv_pkg::CFG_ANGLE_MIN, 20'd0);
    write_register(wcv_pkg::CFG_ANGLE_MAX, 20'hFFFFF);
    write_register(wcv_pkg::CFG_UP_WEIGHT, 20'd0);
    for (n = 0; n < wcv_pkg::WINDOW_DEF; n++) offer_frame(13'($urandom), 1'b1, 20'($urandom));
    wait_idle();

    for (phase = 0; phase < 8; phase++) begin
      src_gaps = (phase < 6);
      sink_stalls = (phase < 6);
      lo = 13'($urandom_range(0, 5760));
      hi = 13'($urandom_range(lo, 5760));
      hi_data = {7'($urandom), hi};
      if (phase == 4) begin
        lo = 13'($urandom_range(1, 5760));
        hi = 13'($urandom_range(0, lo - 1));
        hi_data = {7'($urandom), hi};
      end else if (phase == 5) begin
        lo = '0;
        hi_data = 20'hFFFFF;
      end
      case (phase)
        1: wt = 4'd15;
        3: wt = 4'd0;
        default: wt = 4'($urandom_range(0, 15));
      endcase
      case ($urandom_range(0, 3))
        0: thr = '0;
        1: thr = '1;
        default: thr = 20'($urandom);
      endcase
      write_register(wcv_pkg::CFG_ANGLE_MIN, {7'($urandom), lo});
      write_register(wcv_pkg::CFG_ANGLE_MAX, hi_data);
      write_register(wcv_pkg::CFG_THRESHOLD, thr);
      write_register(wcv_pkg::CFG_UP_WEIGHT, {16'($urandom), wt});
      write_register(CFG_FIRST_UNUSED + 3'($urandom_range(0, 3)), 20'($urandom));
      if (phase == 2) long_hold_req = 1'b1;
      for (n = 0; n < 235; n++) begin
        av = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
          0: ang = 13'(frames.lo_angle + $urandom_range(0, 4) - 2);
          1: ang = 13'(frames.hi_angle + $urandom_range(0, 4) - 2);
          2: ang = 13'($urandom_range(5760, 8191));
          default: ang = 13'($urandom_range(0, 5759));
        endcase
        case ($urandom_range(0, 5))
          0: pix = 20'(frames.threshold + $urandom_range(0, 2) - 1);
          1: pix = '0;
          2: pix = '1;
          default: pix = 20'($urandom);
        endcase
        offer_frame(ang, av, pix);
      end
      wait_idle();
    end

    if (frames.mismatches == 0 && frames.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
